/* sv/reply_frame_checker_decoder_core_macros.svh */
// ----------------------------------------------------------------------------
// reply frame checker assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef REPLY_FRAME_CHECKER_DECODER_CORE_MACROS_SVH
`define REPLY_FRAME_CHECKER_DECODER_CORE_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define RFCD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfcd assertion failed");
// antecedent implies consequent in the next cycle
`define RFCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfcd assertion failed");
`else
`define RFCD_ASSERT_SAME(label, clk, rst, ante, cons)
`define RFCD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/rfcd_pkg.sv */
// ----------------------------------------------------------------------------
// rfcd_pkg
// constants, report codes and hex helpers for the reply frame checker
// ----------------------------------------------------------------------------
package rfcd_pkg;

  localparam int unsigned FRAME_STORE_DEPTH_DEF = 22;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] TYPE_STATUS = 8'h30;
  localparam logic [7:0] TYPE_FIRST  = 8'h31;
  localparam logic [7:0] TYPE_LAST   = 8'h33;

  localparam logic [7:0] R_SIZE   = 8'd22;
  localparam logic [7:0] ACK_SIZE = 8'd14;
  localparam logic [7:0] MIN_SIZE = 8'd5;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [3:0] {
    KIND_STATUS    = 4'd0,
    KIND_POSITION  = 4'd1,
    KIND_TEMP_VOLT = 4'd2,
    KIND_LVDT      = 4'd3,
    KIND_ACK       = 4'd4,
    KIND_TOO_SHORT = 4'd5,
    KIND_CHECKSUM  = 4'd6,
    KIND_SIZE_ERR  = 4'd7,
    KIND_TYPE_ERR  = 4'd8,
    KIND_UNKNOWN   = 4'd9
  } report_kind_t;

  typedef struct packed {
    report_kind_t report_kind;
    logic [7:0]   status_byte;
    logic [31:0]  status_chars;
    logic [31:0]  first_value;
    logic [31:0]  second_value;
    logic [7:0]   reply_letter;
    logic [7:0]   computed_checksum;
    logic [7:0]   frame_size;
  } report_t;

  // uppercase hex character for the low nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  // unchecked hex character value, mod 256
  function automatic logic [7:0] char_val(input logic [7:0] c);
    return (c >= 8'h41) ? (c - 8'h37) : (c - 8'h30);
  endfunction

  // two characters to one byte, high character first
  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] vh;
    vh = char_val(hi);
    return {vh[3:0], 4'h0} + char_val(lo);
  endfunction

endpackage

/* sv/rfcd_byte_if.sv */
// ----------------------------------------------------------------------------
// rfcd_byte_if
// received byte channel, one byte per word
// ----------------------------------------------------------------------------
interface rfcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/rfcd_report_if.sv */
// ----------------------------------------------------------------------------
// rfcd_report_if
// decoded report channel, one report per word
// ----------------------------------------------------------------------------
interface rfcd_report_if;
  logic        valid;
  logic        ready;
  logic [3:0]  report_kind;
  logic [7:0]  status_byte;
  logic [31:0] status_chars;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic [7:0]  reply_letter;
  logic [7:0]  computed_checksum;
  logic [7:0]  frame_size;

  modport source (
    output valid, output report_kind, output status_byte, output status_chars,
    output first_value, output second_value, output reply_letter,
    output computed_checksum, output frame_size, input ready
  );
  modport sink (
    input valid, input report_kind, input status_byte, input status_chars,
    input first_value, input second_value, input reply_letter,
    input computed_checksum, input frame_size, output ready
  );
endinterface

/* sv/reply_frame_checker_decoder_core.sv */
// ----------------------------------------------------------------------------
// reply_frame_checker_decoder_core
// hunts for '$', collects a frame up to '#', checks and decodes it
// latency: a report is valid the cycle after its closing '#' word is taken
// throughput: one byte word per cycle; the report register frees its slot in
//   the same cycle it is taken, so input stalls only while a report waits
// reset: synchronous, active high; clears hunt state and the report valid,
//   the frame store holds no reset value
// ----------------------------------------------------------------------------
`include "reply_frame_checker_decoder_core_macros.svh"

module reply_frame_checker_decoder_core #(
  parameter int unsigned FRAME_STORE_DEPTH = rfcd_pkg::FRAME_STORE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rfcd_byte_if.sink     rx,
  rfcd_report_if.source report
);
  import rfcd_pkg::*;

  localparam int unsigned IDX_W = $clog2(FRAME_STORE_DEPTH);
  localparam logic [7:0]  DEPTH_B = 8'(FRAME_STORE_DEPTH);

  // frame collection state
  logic       in_frame;
  logic [7:0] byte_count;
  logic [7:0] running_xor;
  logic [7:0] last_byte;
  logic [7:0] second_last_byte;
  // frame store, only fixed positions are ever read
  logic [7:0] frame_bytes [FRAME_STORE_DEPTH];

  // report output register
  logic    out_valid;
  report_t report_q;
  report_t report_next;

  logic       rx_take;
  logic       frame_close;
  logic [7:0] size;
  logic [7:0] cs;
  logic [7:0] letter;
  logic [7:0] type_char;

  // a new byte is taken whenever the report slot is empty or draining
  assign rx.ready    = !out_valid || report.ready;
  assign rx_take     = rx.valid && rx.ready;
  assign frame_close = rx_take && in_frame && (rx.rx_byte == CH_END);

  // ---------------------------------------------------------------------------
  // frame collection: one byte per accepted word
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      byte_count       <= 8'd0;
      running_xor      <= 8'd0;
      last_byte        <= 8'd0;
      second_last_byte <= 8'd0;
    end else if (rx_take) begin
      if (!in_frame) begin
        // hunting: everything but the start mark is dropped
        if (rx.rx_byte == CH_START) begin
          in_frame         <= 1'b1;
          byte_count       <= 8'd1;
          running_xor      <= rx.rx_byte;
          last_byte        <= rx.rx_byte;
          second_last_byte <= 8'd0;
        end
      end else if (rx.rx_byte != CH_END) begin
        // inside a frame, '$' is plain data
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + 8'd1;
        end
        running_xor      <= running_xor ^ rx.rx_byte;
        second_last_byte <= last_byte;
        last_byte        <= rx.rx_byte;
      end else begin
        // closing mark, report goes out through the output register
        in_frame <= 1'b0;
      end
    end
  end

  // frame store writes, bytes past the store depth only count
  always_ff @(posedge clk) begin
    if (rx_take) begin
      if (!in_frame && rx.rx_byte == CH_START) begin
        frame_bytes[0] <= rx.rx_byte;
      end else if (in_frame && rx.rx_byte != CH_END && byte_count < DEPTH_B) begin
        frame_bytes[byte_count[IDX_W-1:0]] <= rx.rx_byte;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // frame check and decode, evaluated on the stored frame as '#' arrives
  // ---------------------------------------------------------------------------
  assign size      = (byte_count == COUNT_MAX) ? COUNT_MAX : byte_count + 8'd1;
  // the two checksum characters are taken back out of the running xor
  assign cs        = running_xor ^ last_byte ^ second_last_byte;
  assign letter    = frame_bytes[1];
  assign type_char = frame_bytes[2];

  always_comb begin
    report_next            = '0;
    report_next.frame_size = size;
    if (size < MIN_SIZE) begin
      report_next.report_kind = KIND_TOO_SHORT;
    end else begin
      report_next.reply_letter      = letter;
      report_next.computed_checksum = cs;
      if (second_last_byte != hex_char(cs[7:4]) || last_byte != hex_char(cs[3:0])) begin
        report_next.report_kind = KIND_CHECKSUM;
      end else if (letter == CH_R) begin
        if (size != R_SIZE) begin
          report_next.report_kind = KIND_SIZE_ERR;
        end else if (type_char == TYPE_STATUS) begin
          report_next.report_kind  = KIND_STATUS;
          report_next.status_byte  = hex_pair(frame_bytes[3], frame_bytes[4]);
          report_next.status_chars = {frame_bytes[8], frame_bytes[7],
                                      frame_bytes[6], frame_bytes[5]};
          report_next.second_value = {hex_pair(frame_bytes[17], frame_bytes[18]),
                                      hex_pair(frame_bytes[15], frame_bytes[16]),
                                      hex_pair(frame_bytes[13], frame_bytes[14]),
                                      hex_pair(frame_bytes[11], frame_bytes[12])};
        end else if (type_char inside {[TYPE_FIRST:TYPE_LAST]}) begin
          // type digit '1'..'3' maps straight onto kinds 1..3
          report_next.report_kind  = report_kind_t'(type_char[3:0]);
          report_next.first_value  = {hex_pair(frame_bytes[9], frame_bytes[10]),
                                      hex_pair(frame_bytes[7], frame_bytes[8]),
                                      hex_pair(frame_bytes[5], frame_bytes[6]),
                                      hex_pair(frame_bytes[3], frame_bytes[4])};
          report_next.second_value = {hex_pair(frame_bytes[17], frame_bytes[18]),
                                      hex_pair(frame_bytes[15], frame_bytes[16]),
                                      hex_pair(frame_bytes[13], frame_bytes[14]),
                                      hex_pair(frame_bytes[11], frame_bytes[12])};
        end else begin
          report_next.report_kind = KIND_TYPE_ERR;
        end
      end else if (letter inside {CH_S, CH_L, CH_V, CH_T}) begin
        // short acknowledge replies
        report_next.report_kind = (size != ACK_SIZE) ? KIND_SIZE_ERR : KIND_ACK;
      end else begin
        report_next.report_kind = KIND_UNKNOWN;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // report register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_close) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_close) begin
      report_q <= report_next;
    end
  end

  assign report.valid             = out_valid;
  assign report.report_kind       = report_q.report_kind;
  assign report.status_byte       = report_q.status_byte;
  assign report.status_chars      = report_q.status_chars;
  assign report.first_value       = report_q.first_value;
  assign report.second_value      = report_q.second_value;
  assign report.reply_letter      = report_q.reply_letter;
  assign report.computed_checksum = report_q.computed_checksum;
  assign report.frame_size        = report_q.frame_size;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every closing mark inside a frame produces a report next cycle
  `RFCD_ASSERT_NEXT(a_close_reports, clk, rst, frame_close, report.valid)
  // an open frame always holds at least its start mark
  `RFCD_ASSERT_SAME(a_count_nonzero, clk, rst, in_frame, byte_count != 8'd0)
  // too short reports carry no letter and a size below the minimum
  `RFCD_ASSERT_SAME(a_short_kind, clk, rst, report.valid && report.report_kind == KIND_TOO_SHORT, report.frame_size < MIN_SIZE && report.reply_letter == 8'd0)
  // decoded reading replies always have the full reply length
  `RFCD_ASSERT_SAME(a_decoded_size, clk, rst, report.valid && report.report_kind < KIND_ACK, report.frame_size == R_SIZE && report.reply_letter == CH_R)

endmodule
